@@ sv/kms_pkg.sv @@
// shared types, constants and key map for the key matrix scanner
`timescale 1ns / 1ps
`default_nettype none
package kms_pkg;

  localparam int ROM_ROWS       = 8;
  localparam int ROM_COLS       = 12;
  localparam int COL_BITS       = 12;
  localparam int KEY_BITS       = 7;
  localparam int ROW_DRIVE_BITS = 8;
  localparam int LANE_KEYS      = 16;
  localparam int LANE_IDX_BITS  = 4;
  localparam int MAX_LANES      = 8;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                     found;
    logic [LANE_IDX_BITS-1:0] idx;
  } lane_hit_t;

  typedef logic [KEY_BITS-1:0] key_row_t [ROM_COLS];

  localparam key_row_t KEY_ROM [ROM_ROWS] = '{
    '{7'd0,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,  7'd10, 7'd11},
    '{7'd13, 7'd12, 7'd16, 7'd14, 7'd23, 7'd22, 7'd18, 7'd15, 7'd17, 7'd19, 7'd21, 7'd20},
    '{7'd25, 7'd24, 7'd34, 7'd35, 7'd30, 7'd28, 7'd31, 7'd32, 7'd33, 7'd26, 7'd27, 7'd29},
    '{7'd44, 7'd47, 7'd41, 7'd45, 7'd37, 7'd38, 7'd39, 7'd40, 7'd36, 7'd43, 7'd46, 7'd42},
    '{7'd59, 7'd58, 7'd50, 7'd56, 7'd53, 7'd48, 7'd52, 7'd57, 7'd51, 7'd55, 7'd49, 7'd54},
    '{7'd71, 7'd70, 7'd63, 7'd60, 7'd66, 7'd65, 7'd64, 7'd61, 7'd62, 7'd67, 7'd68, 7'd69},
    '{7'd82, 7'd83, 7'd73, 7'd74, 7'd78, 7'd81, 7'd75, 7'd76, 7'd72, 7'd80, 7'd79, 7'd77},
    '{7'd0,  7'd0,  7'd0,  7'd0,  7'd85, 7'd86, 7'd0,  7'd0,  7'd0,  7'd0,  7'd84, 7'd87}
  };

  // positions in use per matrix row, bit c for column c
  localparam logic [COL_BITS-1:0] ROM_VALID [ROM_ROWS] = '{
    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hC30
  };

  function automatic logic [KEY_BITS-1:0] rom_key(input logic [2:0] row,
                                                  input logic [3:0] col);
    key_row_t r;
    r = KEY_ROM[row];
    return r[col];
  endfunction

endpackage
`default_nettype wire

@@ sv/kms_lane.sv @@
// one search lane: lowest pressed key at or above the start key in a group of sixteen
`timescale 1ns / 1ps
`default_nettype none
module kms_lane
  import kms_pkg::*;
#(
  parameter int LANE = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [LANE_KEYS-1:0] keys,
  input  wire logic [KEY_BITS-1:0]  start_key,
  output lane_hit_t                 hit
);

  logic [LANE_KEYS-1:0] cand;
  lane_hit_t            hit_next;

  always_comb begin
    for (int i = 0; i < LANE_KEYS; i++) begin
      cand[i] = keys[i] && ((LANE * LANE_KEYS + i) >= int'(start_key));
    end
  end

  // scan from the top so the lowest candidate wins
  always_comb begin
    hit_next = '0;
    for (int i = LANE_KEYS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_next.found = 1'b1;
        hit_next.idx   = LANE_IDX_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/kms_merge.sv @@
// merges the lane results into the lowest pressed key
`timescale 1ns / 1ps
`default_nettype none
module kms_merge
  import kms_pkg::*;
#(
  parameter int LANES = 6
) (
  input  lane_hit_t                 hits [LANES],
  output logic                      found,
  output logic [KEY_BITS-1:0]       pressed_key
);

  always_comb begin
    found       = 1'b0;
    pressed_key = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hits[l].found) begin
        found       = 1'b1;
        pressed_key = (KEY_BITS'(l) << LANE_IDX_BITS) | KEY_BITS'(hits[l].idx);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/key_matrix_scanner.sv @@
// top level of the key matrix scanner
`timescale 1ns / 1ps
`default_nettype none
// Scans a key matrix one row at a time. A column-sample word (tuser kind 0)
// stores the pressed bits of the keys on the driven row and steps to the next
// row; a query word (tuser kind 1) returns the lowest pressed key at or above
// start_key, so pressed keys can be listed by querying again from the last
// key found plus one. Every input word gives one output word. A new word is
// taken every cycle while the output is not stalled by m_tready. The query
// runs in sixteen-key lanes whose registered hits are merged into the output
// register. row_drive always shows the row to drive for the next sample.
module key_matrix_scanner
  import kms_pkg::*;
#(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 12,
  parameter int KEYS    = 88
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // column_bits[11:0], start_key[18:12], zero
  input  wire logic [0:0]  s_tuser,   // kind[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // row_drive[7:0], found[8], pressed_key[15:9]
);

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW    = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int NCOL  = (COLUMNS < ROM_COLS) ? COLUMNS : ROM_COLS;
  localparam int LANES = (KEYS + LANE_KEYS - 1) / LANE_KEYS;

  logic [COL_BITS-1:0] column_bits;
  logic [KEY_BITS-1:0] start_key;
  kind_t               kind;

  assign column_bits = s_tdata[11:0];
  assign start_key   = s_tdata[18:12];
  assign kind        = kind_t'(s_tuser[0]);

  logic accept, out_adv;
  logic s1_valid;
  kind_t s1_kind;
  logic [ROW_DRIVE_BITS-1:0] s1_drive;

  assign out_adv  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_adv;
  assign accept   = s_tvalid && s_tready;

  // row counter
  logic [RW-1:0] row_idx, row_next, row_shown;
  logic [ROW_DRIVE_BITS-1:0] drive_next;

  always_comb begin
    if (32'(row_idx) + 1 >= ROWS) begin
      row_next = '0;
    end else begin
      row_next = row_idx + RW'(1);
    end
    row_shown = (kind == KIND_SAMPLE) ? row_next : row_idx;
    for (int r = 0; r < ROW_DRIVE_BITS; r++) begin
      drive_next[r] = (32'(row_shown) == r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_idx <= '0;
    end else if (accept && kind == KIND_SAMPLE) begin
      row_idx <= row_next;
    end
  end

  // key map lookup for the driven row, all columns at once
  logic          row_ok;
  logic [2:0]    rom_row;
  logic [NCOL-1:0] wr_en;
  logic [KW-1:0] wr_key [NCOL];
  logic [KEY_BITS-1:0] rk [NCOL];

  assign row_ok  = 32'(row_idx) < ROM_ROWS;
  assign rom_row = 3'(row_idx);

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      rk[c]     = rom_key(rom_row, 4'(c));
      wr_en[c]  = row_ok && ROM_VALID[rom_row][c] && (32'(rk[c]) < KEYS);
      wr_key[c] = rk[c][KW-1:0];
    end
  end

  logic [KEYS-1:0] key_pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pressed <= '0;
    end else if (accept && kind == KIND_SAMPLE) begin
      for (int c = 0; c < NCOL; c++) begin
        if (wr_en[c]) begin
          key_pressed[wr_key[c]] <= column_bits[c];
        end
      end
    end
  end

  // search lanes
  logic [LANES*LANE_KEYS-1:0] key_vec;
  lane_hit_t hits [LANES];

  assign key_vec = (LANES * LANE_KEYS)'(key_pressed);

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    kms_lane #(
      .LANE(l)
    ) u_lane (
      .clk      (clk),
      .en       (accept),
      .keys     (key_vec[l*LANE_KEYS +: LANE_KEYS]),
      .start_key(start_key),
      .hit      (hits[l])
    );
  end

  logic                merge_found;
  logic [KEY_BITS-1:0] merge_key;

  kms_merge #(
    .LANES(LANES)
  ) u_merge (
    .hits       (hits),
    .found      (merge_found),
    .pressed_key(merge_key)
  );

  // first stage control and side data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= kind;
      s1_drive <= drive_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      m_tdata[7:0] <= s1_drive;
      if (s1_kind == KIND_QUERY) begin
        m_tdata[8]    <= merge_found;
        m_tdata[15:9] <= merge_key;
      end else begin
        m_tdata[8]    <= 1'b0;
        m_tdata[15:9] <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/key_matrix_scanner_tb.sv @@
// self-checking testbench for the key matrix scanner: scans, queries and key enumeration
`timescale 1ns / 1ps
module key_matrix_scanner_tb;
  import kms_pkg::*;

  localparam int KEY_COUNT = 88;
  localparam int NUM_COLS  = 12;
  localparam int LAST_ROW  = 7;
  localparam int ITEM_GOAL = 1150;
  localparam int CALM_FROM = 1000;
  localparam logic [6:0] NO_KEY = 7'd127;

  // key number per matrix position, row-major; NO_KEY marks a position not wired
  localparam logic [6:0] KEY_MAP [0:95] = '{
    7'd0,   7'd1,   7'd2,   7'd3,   7'd4,   7'd5,   7'd6,   7'd7,   7'd8,   7'd9,   7'd10,  7'd11,
    7'd13,  7'd12,  7'd16,  7'd14,  7'd23,  7'd22,  7'd18,  7'd15,  7'd17,  7'd19,  7'd21,  7'd20,
    7'd25,  7'd24,  7'd34,  7'd35,  7'd30,  7'd28,  7'd31,  7'd32,  7'd33,  7'd26,  7'd27,  7'd29,
    7'd44,  7'd47,  7'd41,  7'd45,  7'd37,  7'd38,  7'd39,  7'd40,  7'd36,  7'd43,  7'd46,  7'd42,
    7'd59,  7'd58,  7'd50,  7'd56,  7'd53,  7'd48,  7'd52,  7'd57,  7'd51,  7'd55,  7'd49,  7'd54,
    7'd71,  7'd70,  7'd63,  7'd60,  7'd66,  7'd65,  7'd64,  7'd61,  7'd62,  7'd67,  7'd68,  7'd69,
    7'd82,  7'd83,  7'd73,  7'd74,  7'd78,  7'd81,  7'd75,  7'd76,  7'd72,  7'd80,  7'd79,  7'd77,
    NO_KEY, NO_KEY, NO_KEY, NO_KEY, 7'd85,  7'd86,  NO_KEY, NO_KEY, NO_KEY, NO_KEY, 7'd84,  7'd87
  };

  typedef struct packed {
    logic [7:0] row_drive;
    logic       found;
    logic [6:0] pressed_key;
  } scan_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // column_bits[11:0], start_key[18:12], zero
  logic [0:0]  s_tuser  = '0;   // kind[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // row_drive[7:0], found[8], pressed_key[15:9]

  // scanner state as predicted
  logic [2:0]           row_now  = '0;
  logic [KEY_COUNT-1:0] key_down = '0;

  scan_result_t pending_results[$];
  scan_result_t head_result;
  bit           idle_on       = 1'b0;
  int           items_sent    = 0;
  int           samples_sent  = 0;
  int           queries_sent  = 0;
  int           queries_found = 0;
  int           results_seen  = 0;
  int           err_count     = 0;

  key_matrix_scanner i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic scan_result_t scan_model_step(input kind_t kind, input logic [11:0] cols,
                                                   input logic [6:0] start);
    scan_result_t res;
    logic [6:0]   key;
    int           k;
    res = '0;
    if (kind == KIND_SAMPLE) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        key = KEY_MAP[row_now * NUM_COLS + c];
        if (key != NO_KEY) key_down[key] = cols[c];
      end
      row_now = (row_now == 3'(LAST_ROW)) ? 3'd0 : row_now + 3'd1;
    end else begin
      // walk down so the last hit is the lowest pressed key
      for (k = KEY_COUNT - 1; k >= int'(start); k--) begin
        if (key_down[k]) begin
          res.found       = 1'b1;
          res.pressed_key = 7'(k);
        end
      end
    end
    res.row_drive = 8'd1 << row_now;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t on %s: got %0d, want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input kind_t kind, input logic [11:0] cols, input logic [6:0] start,
                           output scan_result_t res);
    int gap;
    if (idle_on && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'd0, start, cols};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    res = scan_model_step(kind, cols, start);
    pending_results.push_back(res);
    items_sent++;
    if (kind == KIND_SAMPLE) samples_sent++;
    else begin
      queries_sent++;
      if (res.found) queries_found++;
    end
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver side: ready drops in random bursts while idling is on
  initial begin : sink_ready
    int burst;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 18);
        m_tready <= 1'b0;
        repeat (burst) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 0);
      end else begin
        head_result = pending_results.pop_front();
        if (m_tdata[7:0] !== head_result.row_drive)
          report_mismatch("row_drive", m_tdata[7:0], head_result.row_drive);
        if (m_tdata[8] !== head_result.found)
          report_mismatch("found", m_tdata[8], head_result.found);
        if (m_tdata[15:9] !== head_result.pressed_key)
          report_mismatch("pressed_key", m_tdata[15:9], head_result.pressed_key);
      end
    end
  end

  task automatic test_reset_state();
    scan_result_t res;
    send_word(KIND_QUERY, 12'h000, 7'd0, res);
    send_word(KIND_QUERY, 12'hFFF, 7'd127, res);
  endtask

  task automatic test_full_matrix();
    scan_result_t res;
    repeat (8) send_word(KIND_SAMPLE, 12'hFFF, 7'd0, res);
    send_word(KIND_QUERY, 12'h000, 7'd0, res);
    send_word(KIND_QUERY, 12'h000, 7'd87, res);
    // first start above the last key
    send_word(KIND_QUERY, 12'h000, 7'd88, res);
    send_word(KIND_QUERY, 12'hFFF, 7'd86, res);
  endtask

  task automatic test_unused_positions();
    scan_result_t res;
    // clear every key; on the last row only the unwired columns are high
    repeat (7) send_word(KIND_SAMPLE, 12'h000, 7'd127, res);
    send_word(KIND_SAMPLE, 12'h3CF, 7'd127, res);
    send_word(KIND_QUERY, 12'hFFF, 7'd0, res);
    send_word(KIND_QUERY, 12'h000, 7'd127, res);
  endtask

  task automatic test_random_traffic();
    scan_result_t res;
    logic [11:0]  cols;
    logic [6:0]   next_start;
    int           mode;
    int           drains;
    drains = 0;
    while (items_sent < ITEM_GOAL) begin
      idle_on = (items_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      if (drains < 2 && items_sent > 300 + drains * 400) begin
        wait_results_drained();
        drains++;
      end
      if ($urandom_range(0, 9) < 7) begin
        // one full scan pass, then list the pressed keys at or above a start key, mostly zero
        mode = $urandom_range(0, 3);
        repeat (8) begin
          case (mode)
            0: cols = 12'($urandom);
            1: cols = 12'($urandom & $urandom & $urandom);
            2: cols = '0;
            default: cols = ($urandom_range(0, 3) == 0) ? 12'hFFF
                                                         : 12'($urandom & $urandom & $urandom);
          endcase
          send_word(KIND_SAMPLE, cols, 7'($urandom), res);
        end
        next_start = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 87)) : 7'd0;
        do begin
          send_word(KIND_QUERY, 12'($urandom), next_start, res);
          next_start = res.pressed_key + 7'd1;
        end while (res.found);
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(kind_t'($urandom_range(0, 1)), 12'($urandom), 7'($urandom), res);
      end
    end
    idle_on = 1'b0;
  endtask

  initial begin : main_seq
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_state();
    test_full_matrix();
    test_unused_positions();
    idle_on = 1'b1;
    test_random_traffic();
    wait_results_drained();
    repeat (10) @(negedge clk);
    $display("covered %0d words: %0d row samples, %0d queries (%0d found a key)",
             items_sent, samples_sent, queries_sent, queries_found);
    $display("%0d result words checked, %0d mismatches", results_seen, err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ key_matrix_scanner.f @@
sv/kms_pkg.sv
sv/kms_lane.sv
sv/kms_merge.sv
sv/key_matrix_scanner.sv
tb/key_matrix_scanner_tb.sv
